// ===== sv/cdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer package
// Shared beat types, mode encoding and constants of the countdown timer.
// ----------------------------------------------------------------------------
package cdt_pkg;

    // Timer modes, also the encoding of the mode result field.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_PAUSE = 2'd3
    } mode_t;

    // Cursor slots past the six digit positions.
    localparam logic [2:0] SLOT_CANCEL = 3'd6;
    localparam logic [2:0] SLOT_START  = 3'd7;
    localparam int         NUM_DIGITS  = 6;

    // Largest displayed remaining time, 99:59:59.
    localparam logic [18:0] REMAIN_MAX = 19'd359999;

    // Reset value of the long press limit.
    localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;

    // Input beat: button events, minus hold state and current time.
    typedef struct packed {
        logic        next_pressed;
        logic        minus_pressed;
        logic        plus_pressed;
        logic        minus_is_down;
        logic [15:0] minus_held_ms;
        logic [31:0] now_sec;
    } cdt_in_t;

    // Result beat: state after the item and alarm requests.
    typedef struct packed {
        mode_t       mode;
        logic [2:0]  cursor;
        logic [18:0] remaining_sec;
        logic [15:0] hold_progress_ms;
        logic        alarm_arm;
        logic        alarm_cancel;
        logic [31:0] fire_time;
        logic        expired;
    } cdt_out_t;

endpackage

// ===== sv/countdown_timer_digit_entry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer with digit entry
// Set, run, pause and expiry control of an HH:MM:SS countdown, one poll beat
// in and one result beat out.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                          Direction  Beat
//  --------  -----------------------------  ---------  -------------------------
//  input     s_valid / s_ready / s_data     in         one poll: buttons, time
//  result    m_valid / m_ready / m_data     out        one result per poll
//  config    cfg_wr_en / cfg_wr_data        in         long press limit, no wait
//
//  A beat is taken into the input register; once the result register is free
//  (empty or taken by m_ready), the timer state and the result register are
//  updated from it. One beat per cycle is sustained while m_ready stays high;
//  the single state update per cycle between the two registers sets that rate.
//  Reset (aresetn low, synchronous) empties both registers and clears the
//  timer state. A stalled result holds; the input register still takes one
//  beat behind it.
//
module countdown_timer_digit_entry (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  cdt_pkg::cdt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cdt_pkg::cdt_out_t m_data
);
    import cdt_pkg::*;

    // Pipeline registers.
    logic     in_valid_reg, in_valid_next;
    cdt_in_t  in_reg;
    logic     out_valid_reg, out_valid_next;
    cdt_out_t out_reg, out_next;
    logic     advance;

    // Timer state.
    logic [15:0] limit_reg;
    mode_t       mode_reg, mode_next;
    logic [2:0]  cursor_reg, cursor_next;
    logic [3:0]  digits_reg [NUM_DIGITS];
    logic [3:0]  digits_next [NUM_DIGITS];
    logic [18:0] remaining_reg, remaining_next;
    logic [31:0] fire_time_reg, fire_time_next;
    logic [31:0] pause_time_reg, pause_time_next;

    // Shared decode of the current beat.
    logic [31:0] diff_run, diff_pause, diff_sel, fire_sum, fire_addend;
    logic [18:0] shown;
    logic [18:0] digit_sum;
    logic [2:0]  cursor_step;
    logic        active, expire_hit, long_hit, was_reset;
    logic        cancel_hit, start_hit, plus_ok;
    logic        arm, cancel;

    // Handshake: the update stage moves when the result register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Time differences, display clamp and the single fire time adder.
    assign diff_run    = fire_time_reg - in_reg.now_sec;
    assign diff_pause  = fire_time_reg - pause_time_reg;
    assign diff_sel    = (mode_reg == MODE_RUN) ? diff_run : diff_pause;
    assign fire_addend = (mode_reg == MODE_SET) ? {13'd0, remaining_reg} : diff_pause;
    assign fire_sum    = in_reg.now_sec + fire_addend;

    always_comb begin
        if (diff_sel[31]) begin
            shown = '0;
        end else if (diff_sel > {13'd0, REMAIN_MAX}) begin
            shown = REMAIN_MAX;
        end else begin
            shown = diff_sel[18:0];
        end
    end

    // Event decode: expiry, long press and the slot under the stepped cursor.
    assign active      = (mode_reg == MODE_RUN) || (mode_reg == MODE_PAUSE);
    assign expire_hit  = (mode_reg == MODE_RUN) && ((diff_run == '0) || diff_run[31]);
    assign long_hit    = active && in_reg.minus_is_down && (in_reg.minus_held_ms > limit_reg);
    assign was_reset   = expire_hit || long_hit;
    assign plus_ok     = in_reg.plus_pressed && !was_reset;
    assign cursor_step = cursor_reg + {2'd0, in_reg.next_pressed};
    assign cancel_hit  = (mode_reg == MODE_SET) && in_reg.plus_pressed
                         && (cursor_step == SLOT_CANCEL);
    assign start_hit   = (mode_reg == MODE_SET) && in_reg.plus_pressed
                         && (cursor_step == SLOT_START);

    // Next mode.
    always_comb begin
        unique case (mode_reg)
            MODE_IDLE: begin
                mode_next = in_reg.plus_pressed ? MODE_SET : MODE_IDLE;
            end
            MODE_SET: begin
                if (cancel_hit) begin
                    mode_next = MODE_IDLE;
                end else if (start_hit) begin
                    mode_next = MODE_RUN;
                end else begin
                    mode_next = MODE_SET;
                end
            end
            MODE_RUN: begin
                if (was_reset) begin
                    mode_next = MODE_IDLE;
                end else if (in_reg.plus_pressed) begin
                    mode_next = MODE_PAUSE;
                end else begin
                    mode_next = MODE_RUN;
                end
            end
            default: begin
                if (long_hit) begin
                    mode_next = MODE_IDLE;
                end else if (in_reg.plus_pressed) begin
                    mode_next = MODE_RUN;
                end else begin
                    mode_next = MODE_PAUSE;
                end
            end
        endcase
    end

    // Cursor, digit edits and the digit-based remaining time.
    always_comb begin
        logic [3:0] d;
        logic [3:0] top;
        cursor_next = cursor_reg;
        if (mode_reg == MODE_SET) begin
            cursor_next = cancel_hit ? 3'd0 : cursor_step;
        end else if (was_reset) begin
            cursor_next = 3'd0;
        end
        for (int i = 0; i < NUM_DIGITS; i++) begin
            // Minute tens and second tens wrap at six, all others at ten.
            top = (i == 2 || i == 4) ? 4'd5 : 4'd9;
            d   = digits_reg[i];
            if (mode_reg == MODE_SET) begin
                if (cancel_hit) begin
                    d = '0;
                end else if (in_reg.plus_pressed && cursor_step == 3'(i)) begin
                    d = (d == top) ? 4'd0 : d + 4'd1;
                end
                if (in_reg.minus_pressed && cursor_next == 3'(i)) begin
                    d = (d == 4'd0) ? top : d - 4'd1;
                end
            end else if (was_reset) begin
                d = '0;
            end
            digits_next[i] = d;
        end
        digit_sum = 19'(digits_next[0]) * 19'd36000 + 19'(digits_next[1]) * 19'd3600
                  + 19'(digits_next[2]) * 19'd600   + 19'(digits_next[3]) * 19'd60
                  + 19'(digits_next[4]) * 19'd10    + 19'(digits_next[5]);
    end

    // Remaining time, fire and pause times, alarm requests.
    always_comb begin
        remaining_next  = remaining_reg;
        fire_time_next  = fire_time_reg;
        pause_time_next = pause_time_reg;
        arm             = 1'b0;
        cancel          = 1'b0;
        unique case (mode_reg)
            MODE_IDLE: begin
            end
            MODE_SET: begin
                remaining_next = digit_sum;
                if (start_hit) begin
                    fire_time_next = fire_sum;
                    arm            = 1'b1;
                end
            end
            MODE_RUN: begin
                remaining_next = was_reset ? 19'd0 : shown;
                cancel         = long_hit || plus_ok;
                if (plus_ok) begin
                    pause_time_next = in_reg.now_sec;
                end
            end
            default: begin
                remaining_next = long_hit ? 19'd0 : shown;
                cancel         = long_hit;
                if (plus_ok) begin
                    fire_time_next = fire_sum;
                    arm            = 1'b1;
                end
            end
        endcase
    end

    // Result beat assembled from the next state.
    always_comb begin
        out_next.mode          = mode_next;
        out_next.cursor        = cursor_next;
        out_next.remaining_sec = remaining_next;
        out_next.hold_progress_ms =
            (active && in_reg.minus_is_down
             && (mode_next == MODE_RUN || mode_next == MODE_PAUSE))
            ? in_reg.minus_held_ms : 16'd0;
        out_next.alarm_arm     = arm;
        out_next.alarm_cancel  = cancel;
        out_next.fire_time     = fire_time_next;
        out_next.expired       = expire_hit;
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // Control and timer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            limit_reg      <= LONG_PRESS_RESET;
            mode_reg       <= MODE_IDLE;
            cursor_reg     <= '0;
            remaining_reg  <= '0;
            fire_time_reg  <= '0;
            pause_time_reg <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                digits_reg[i] <= '0;
            end
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (advance) begin
                mode_reg       <= mode_next;
                cursor_reg     <= cursor_next;
                remaining_reg  <= remaining_next;
                fire_time_reg  <= fire_time_next;
                pause_time_reg <= pause_time_next;
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    digits_reg[i] <= digits_next[i];
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer testbench
// Drives poll beats into the countdown timer with random gaps and output
// stalls, predicts every result beat with a behavioral model of the timer,
// and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
    import cdt_pkg::*;

    localparam int QUIET_LIMIT = 3000;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    cdt_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    cdt_out_t    m_data;

    // Predicted timer state, updated at each accepted poll beat.
    mode_t       t_mode = MODE_IDLE;
    logic [2:0]  t_cursor = '0;
    logic [3:0]  t_digits [NUM_DIGITS] = '{default: 4'd0};
    logic [18:0] t_remaining = '0;
    logic [31:0] t_fire = '0;
    logic [31:0] t_pause = '0;
    logic [15:0] t_limit = LONG_PRESS_RESET;

    // Results still owed by the block, oldest first.
    cdt_out_t    timer_expect [$];

    logic [31:0] wall_sec;
    int          mismatches = 0;
    int          results_seen = 0;
    int          hold_request = 0;
    bit          no_idle = 1'b0;

    countdown_timer_digit_entry dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Timer prediction
    // ------------------------------------------------------------------------

    function automatic void clear_entry();
        t_mode = MODE_IDLE;
        t_cursor = '0;
        foreach (t_digits[i]) t_digits[i] = 4'd0;
        t_remaining = '0;
    endfunction

    // Minute tens and second tens count to six, the rest to ten.
    function automatic int digit_wrap(input logic [2:0] pos);
        return (pos == 3'd2 || pos == 3'd4) ? 6 : 10;
    endfunction

    // Negative differences display as zero, large ones saturate.
    function automatic logic [18:0] shown_left(input logic [31:0] diff);
        if (diff[31]) return '0;
        else if (diff > 32'(REMAIN_MAX)) return REMAIN_MAX;
        else return diff[18:0];
    endfunction

    function automatic cdt_out_t step_timer(input cdt_in_t b);
        cdt_out_t    r;
        logic [31:0] diff;
        int          wrap;
        int          total;
        logic        held_seen;
        logic        was_reset;
        r = '0;
        held_seen = 1'b0;
        was_reset = 1'b0;
        case (t_mode)
            MODE_IDLE: begin
                if (b.plus_pressed) t_mode = MODE_SET;
            end
            MODE_SET: begin
                // Cursor first, then plus at the new cursor, then minus.
                if (b.next_pressed) t_cursor = t_cursor + 3'd1;
                if (b.plus_pressed) begin
                    if (t_cursor < SLOT_CANCEL) begin
                        wrap = digit_wrap(t_cursor);
                        t_digits[t_cursor] = 4'((int'(t_digits[t_cursor]) + 1) % wrap);
                    end else if (t_cursor == SLOT_CANCEL) begin
                        clear_entry();
                    end else begin
                        // Start uses the remaining value of the previous beat.
                        t_mode = MODE_RUN;
                        t_fire = b.now_sec + 32'(t_remaining);
                        r.alarm_arm = 1'b1;
                    end
                end
                if (b.minus_pressed && t_cursor < SLOT_CANCEL) begin
                    wrap = digit_wrap(t_cursor);
                    t_digits[t_cursor] = 4'((int'(t_digits[t_cursor]) + wrap - 1) % wrap);
                end
                total = (int'(t_digits[0]) * 10 + int'(t_digits[1])) * 3600
                      + (int'(t_digits[2]) * 10 + int'(t_digits[3])) * 60
                      + int'(t_digits[4]) * 10 + int'(t_digits[5]);
                t_remaining = 19'(total);
            end
            MODE_RUN: begin
                diff = t_fire - b.now_sec;
                t_remaining = shown_left(diff);
                if (diff == 32'd0 || diff[31]) begin
                    clear_entry();
                    r.expired = 1'b1;
                    was_reset = 1'b1;
                end
                if (b.minus_is_down) begin
                    held_seen = 1'b1;
                    if (b.minus_held_ms > t_limit) begin
                        clear_entry();
                        r.alarm_cancel = 1'b1;
                        was_reset = 1'b1;
                    end
                end
                if (b.plus_pressed && !was_reset) begin
                    t_mode = MODE_PAUSE;
                    r.alarm_cancel = 1'b1;
                    t_pause = b.now_sec;
                end
            end
            default: begin
                // Resume works from the full difference, not the display value.
                diff = t_fire - t_pause;
                t_remaining = shown_left(diff);
                if (b.minus_is_down) begin
                    held_seen = 1'b1;
                    if (b.minus_held_ms > t_limit) begin
                        clear_entry();
                        r.alarm_cancel = 1'b1;
                        was_reset = 1'b1;
                    end
                end
                if (b.plus_pressed && !was_reset) begin
                    t_mode = MODE_RUN;
                    t_fire = b.now_sec + diff;
                    r.alarm_arm = 1'b1;
                end
            end
        endcase
        r.mode = t_mode;
        r.cursor = t_cursor;
        r.remaining_sec = t_remaining;
        r.hold_progress_ms = (held_seen && (t_mode == MODE_RUN || t_mode == MODE_PAUSE))
                           ? b.minus_held_ms : 16'd0;
        r.fire_time = t_fire;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly no gap, often a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Builds a poll beat that suits the predicted mode, with some noise.
    function automatic cdt_in_t make_poll();
        cdt_in_t b;
        int      r;
        b = '0;
        r = $urandom_range(0, 99);
        if (r < 70) wall_sec += $urandom_range(0, 2);
        else if (r < 92) wall_sec += $urandom_range(3, 30);
        else if (r < 98) wall_sec += $urandom_range(0, 400000);
        else wall_sec = $urandom;
        b.now_sec = wall_sec;
        if ($urandom_range(0, 9) == 0) begin
            b = cdt_in_t'(52'({$urandom, $urandom}));
            return b;
        end
        case (t_mode)
            MODE_IDLE: begin
                b.plus_pressed = ($urandom_range(0, 99) < 60);
                b.next_pressed = ($urandom_range(0, 3) == 0);
                b.minus_pressed = ($urandom_range(0, 3) == 0);
            end
            MODE_SET: begin
                r = $urandom_range(0, 99);
                if (t_cursor == SLOT_START) begin
                    b.plus_pressed = (r < 60);
                end else if (t_cursor == SLOT_CANCEL) begin
                    b.plus_pressed = (r < 8);
                end else begin
                    b.plus_pressed = (r < 30);
                    b.minus_pressed = (r >= 20 && r < 45);
                end
                b.next_pressed = ($urandom_range(0, 99) < 45);
            end
            default: begin
                b.plus_pressed = ($urandom_range(0, 99) < ((t_mode == MODE_PAUSE) ? 30 : 8));
                if ($urandom_range(0, 99) < 20) begin
                    b.minus_is_down = 1'b1;
                    b.minus_pressed = ($urandom_range(0, 3) == 0);
                    if ($urandom_range(0, 3) == 0) begin
                        b.minus_held_ms = 16'($urandom);
                    end else begin
                        b.minus_held_ms = t_limit + 16'($urandom_range(0, 4)) - 16'd2;
                    end
                end
            end
        endcase
        return b;
    endfunction

    // Offers one poll beat and records its prediction once it is accepted.
    task automatic send_poll(input cdt_in_t beat);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (s_ready !== 1'b1);
        timer_expect.push_back(step_timer(beat));
    endtask

    task automatic send_buttons(input logic nx, input logic mn, input logic pl,
                                input logic dn, input logic [15:0] held,
                                input logic [31:0] now);
        cdt_in_t b;
        b.next_pressed = nx;
        b.minus_pressed = mn;
        b.plus_pressed = pl;
        b.minus_is_down = dn;
        b.minus_held_ms = held;
        b.now_sec = now;
        send_poll(b);
    endtask

    // Stops offering beats and waits until every result has come back.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (timer_expect.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_press_limit(input logic [15:0] limit);
        settle_block();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        t_limit = limit;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // In idle mode only a plus press acts.
    task automatic test_idle_ignores_buttons();
        send_buttons(1'b1, 1'b1, 1'b0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 32'h0000_0000);
    endtask

    // Digits wrap from zero down to the top, minute and second tens at six.
    task automatic test_digit_entry();
        send_buttons(1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 32'd10);
        send_buttons(1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 32'd10);
        send_buttons(1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 32'd10);
        send_buttons(1'b1, 1'b1, 1'b1, 1'b0, 16'd0, 32'd10);
        send_buttons(1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 32'd10);
        send_buttons(1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 32'd10);
    endtask

    // Plus at the cancel slot clears, while minus in the same beat hits digit zero.
    task automatic test_cancel_slot();
        send_buttons(1'b1, 1'b1, 1'b1, 1'b0, 16'd0, 32'd20);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 32'd20);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 32'd20);
    endtask

    // Start near the top of the time range so the fire time wraps, then a
    // saturated display, a pause with the hold exactly at the limit and a resume.
    task automatic test_start_pause_resume();
        send_buttons(1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 32'hFFFF_FFF0);
        send_buttons(1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 32'hFFFF_FFF0);
        send_buttons(1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 32'hFFFF_FFF0);
        send_buttons(1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 32'hFFFF_FFF0);
        send_buttons(1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 32'hFFFF_FFF0);
        send_buttons(1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 32'hFFFF_FFF0);
        send_buttons(1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 32'hFFFF_FFF8);
        send_buttons(1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 32'd3 - 32'd400000);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b1, LONG_PRESS_RESET, 32'hFFFF_FFFA);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 32'd100);
    endtask

    // A long hold and a plus press before the fire time is reached: cancel
    // and reset in one beat, the plus press is dropped.
    task automatic test_expiry_with_long_press();
        send_buttons(1'b0, 1'b1, 1'b1, 1'b1, LONG_PRESS_RESET + 16'd1, 32'd120);
    endtask

    // Resume after a pause whose difference is above the display range, then
    // a long hold while paused.
    task automatic test_full_resume_difference();
        send_buttons(1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 32'd200);
        repeat (6) send_buttons(1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 32'd200);
        send_buttons(1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 32'h8000_0000);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 32'h8000_0000 - 32'd400000);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 32'd5);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 32'd6);
        send_buttons(1'b0, 1'b1, 1'b1, 1'b1, LONG_PRESS_RESET + 16'd1, 32'd7);
    endtask

    // The result side holds off while beats keep coming, so the input stalls.
    task automatic test_output_backpressure();
        no_idle = 1'b1;
        hold_request = 60;
        repeat (24) send_poll(make_poll());
        no_idle = 1'b0;
    endtask

    // Random polls under a series of long press limits, extremes included.
    task automatic test_press_limit_sweep();
        logic [15:0] limits [6];
        limits = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'hFFFE, 16'd3000};
        limits[3] = 16'($urandom);
        foreach (limits[i]) begin
            set_press_limit(limits[i]);
            for (int n = 0; n < 170; n++) begin
                if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
                send_poll(make_poll());
            end
            no_idle = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls and hold-off requests
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        stall = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 2) == 0) stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] seen);
        if (want !== seen) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Result %0d: %s expected %0h, got %0h",
                         results_seen, name, want, seen);
            end
        end
    endfunction

    always @(posedge aclk) begin : result_check
        cdt_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (timer_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result %0d: beat arrived with nothing expected", results_seen);
                end
            end else begin
                want = timer_expect.pop_front();
                check_field("mode", 32'(want.mode), 32'(m_data.mode));
                check_field("cursor", 32'(want.cursor), 32'(m_data.cursor));
                check_field("remaining_sec", 32'(want.remaining_sec),
                            32'(m_data.remaining_sec));
                check_field("hold_progress_ms", 32'(want.hold_progress_ms),
                            32'(m_data.hold_progress_ms));
                check_field("alarm_arm", 32'(want.alarm_arm), 32'(m_data.alarm_arm));
                check_field("alarm_cancel", 32'(want.alarm_cancel),
                            32'(m_data.alarm_cancel));
                check_field("fire_time", want.fire_time, m_data.fire_time);
                check_field("expired", 32'(want.expired), 32'(m_data.expired));
            end
            results_seen++;
        end
    end

    // Ends the run when no beat moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        wall_sec = $urandom;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_ignores_buttons();
        test_digit_entry();
        test_cancel_slot();
        test_start_pause_resume();
        test_expiry_with_long_press();
        test_full_resume_difference();
        test_output_backpressure();
        test_press_limit_sweep();
        settle_block();
        if (mismatches == 0 && timer_expect.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
